// ===== sv/pem_pkg.sv =====
// ----------------------------------------------------------------------------
// pem_pkg
// Shared types and constants for the pitch epoch marker.
// ----------------------------------------------------------------------------
`default_nettype none

package pem_pkg;

  localparam int unsigned MaxSamples = 4096;
  localparam int unsigned SampleAw   = $clog2(MaxSamples);
  localparam int unsigned CountW     = SampleAw + 1;
  localparam int unsigned MaxEpochs  = 64;
  localparam int unsigned EpochAw    = $clog2(MaxEpochs);
  localparam int unsigned EpochCntW  = EpochAw + 1;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QAw        = $clog2(QDepth);

  localparam logic [11:0] PeriodReset    = 12'd64;
  localparam logic [7:0]  HalfWidthReset = 8'd30;

  // register index, taken from paddr[2]
  localparam logic RegPitchPeriod = 1'b0;
  localparam logic RegHalfWidth   = 1'b1;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last_sample;
  } pem_in_t;

  typedef struct packed {
    logic [11:0] epoch_position;
    logic        last_epoch;
  } pem_out_t;

  typedef struct packed {
    logic [11:0] pitch_period;
    logic [7:0]  search_half_width;
  } pem_cfg_t;

  // one classified input transfer, as queued for the back end
  typedef struct packed {
    logic                we;
    logic                last;
    logic [SampleAw-1:0] addr;
    logic signed [15:0]  data;
    logic [CountW-1:0]   n;
  } pem_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pem_q_stat_t;

endpackage

`default_nettype wire

// ===== sv/pem_front.sv =====
// ----------------------------------------------------------------------------
// pem_front
// Accepts samples, tracks the buffer fill and tags each transfer with its
// store address, drop status and closing count.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_front
  import pem_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire pem_in_t  in_data_i,
  input  wire logic     q_full_i,
  output logic          q_push_o,
  output pem_job_t      q_job_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              room;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign room       = count_q < CountW'(MaxSamples);

  always_comb begin
    q_job_o.we   = room;
    q_job_o.last = in_data_i.last_sample;
    q_job_o.addr = count_q[SampleAw-1:0];
    q_job_o.data = in_data_i.sample;
    q_job_o.n    = room ? count_q + CountW'(1) : count_q;
    count_d      = count_q;
    if (q_push_o) begin
      count_d = in_data_i.last_sample ? '0 : q_job_o.n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pem_queue.sv =====
// ----------------------------------------------------------------------------
// pem_queue
// Short FIFO of classified transfers between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_queue
  import pem_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire pem_job_t push_job_i,
  input  wire logic     pop_i,
  output pem_job_t      pop_job_o,
  output pem_q_stat_t   stat_o
);

  pem_job_t         slot_q [QDepth];
  logic [QAw-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QAw:0]     fill_q, fill_d;

  assign stat_o.full  = fill_q == (QAw + 1)'(QDepth);
  assign stat_o.empty = fill_q == '0;
  assign pop_job_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QAw'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QAw'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + (QAw + 1)'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - (QAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pem_back.sv =====
// ----------------------------------------------------------------------------
// pem_back
// Writes samples to the buffer memory, then on the closing transfer runs the
// peak scan, period remainder, grid build, window refinement and emission.
// ----------------------------------------------------------------------------
`default_nettype none

module pem_back
  import pem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pem_cfg_t    cfg_i,
  input  wire pem_q_stat_t q_stat_i,
  input  wire pem_job_t    q_job_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pem_out_t         out_data_o
);

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_GPEAK,
    ST_REM,
    ST_GRID,
    ST_RFETCH,
    ST_RWAIT,
    ST_RSCAN,
    ST_EREAD,
    ST_EWAIT
  } state_e;

  // sample buffer and epoch list
  logic signed [15:0] smem [MaxSamples];
  logic [11:0]        emem [MaxEpochs];
  logic signed [15:0] smp_rd_q;
  logic [11:0]        ep_rd_q;
  logic               smp_rd_en;
  logic               ep_we;
  logic [11:0]        ep_wd;
  logic [EpochAw-1:0] ep_wa;

  state_e               state_q, state_d;
  logic [CountW-1:0]    n_q, n_d;
  logic [CountW-1:0]    scan_addr_q, scan_addr_d, scan_hi_q, scan_hi_d;
  logic                 pend_q, pend_d, first_q, first_d;
  logic [SampleAw-1:0]  pend_idx_q, pend_idx_d, best_idx_q, best_idx_d;
  logic signed [15:0]   best_val_q, best_val_d;
  logic [12:0]          rem_q, rem_d;
  logic [3:0]           bit_q, bit_d;
  logic [CountW-1:0]    pos_q, pos_d;
  logic [EpochCntW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic                 out_valid_q, out_valid_d;
  pem_out_t             out_q, out_d;

  logic [11:0]       period;
  logic              scan_st, scan_more, scan_done;
  logic [12:0]       rem_sh, rem_new;
  logic [11:0]       win_lo;
  logic [CountW-1:0] win_sum, win_hi;
  logic [EpochCntW-1:0] idx_inc;

  assign period      = (cfg_i.pitch_period == '0) ? 12'd1 : cfg_i.pitch_period;
  assign scan_st     = (state_q == ST_GPEAK) || (state_q == ST_RSCAN);
  assign scan_more   = scan_addr_q < scan_hi_q;
  assign scan_done   = !scan_more && !pend_q;
  assign smp_rd_en   = scan_st && scan_more;
  assign q_pop_o     = (state_q == ST_LOAD) && !q_stat_i.empty;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign idx_inc     = idx_q + EpochCntW'(1);

  // one restoring step of peak mod period, MSB first
  assign rem_sh  = {rem_q[11:0], best_idx_q[bit_q]};
  assign rem_new = (rem_sh >= {1'b0, period}) ? rem_sh - {1'b0, period} : rem_sh;

  // refinement window [lo, hi), clamped to the buffer
  assign win_lo  = (ep_rd_q > 12'(cfg_i.search_half_width))
                 ? ep_rd_q - 12'(cfg_i.search_half_width) : '0;
  assign win_sum = CountW'(ep_rd_q) + CountW'(cfg_i.search_half_width);
  assign win_hi  = (win_sum > n_q) ? n_q : win_sum;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    scan_addr_d = scan_addr_q;
    scan_hi_d   = scan_hi_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    first_d     = first_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    ep_we       = 1'b0;
    ep_wa       = idx_q[EpochAw-1:0];
    ep_wd       = 12'(best_idx_q);

    // scan pipeline: issue a read, compare in the next cycle
    if (smp_rd_en) begin
      pend_d      = 1'b1;
      pend_idx_d  = scan_addr_q[SampleAw-1:0];
      scan_addr_d = scan_addr_q + CountW'(1);
    end
    if (pend_q) begin
      if (first_q || (smp_rd_q > best_val_q)) begin
        best_val_d = smp_rd_q;
        best_idx_d = pend_idx_q;
      end
      first_d = 1'b0;
    end

    case (state_q)
      ST_LOAD: begin
        if (q_pop_o && q_job_i.last) begin
          n_d         = q_job_i.n;
          scan_addr_d = '0;
          scan_hi_d   = q_job_i.n;
          first_d     = 1'b1;
          state_d     = ST_GPEAK;
        end
      end
      ST_GPEAK: begin
        if (scan_done) begin
          rem_d   = '0;
          bit_d   = 4'(SampleAw - 1);
          state_d = ST_REM;
        end
      end
      ST_REM: begin
        rem_d = rem_new;
        bit_d = bit_q - 4'd1;
        if (bit_q == '0) begin
          // leftmost point stays above 0 unless it is the peak
          pos_d   = (rem_new == '0 && best_idx_q != '0) ? CountW'(period)
                                                        : CountW'(rem_new);
          cnt_d   = '0;
          state_d = ST_GRID;
        end
      end
      ST_GRID: begin
        if (pos_q < n_q && cnt_q < EpochCntW'(MaxEpochs)) begin
          ep_we = 1'b1;
          ep_wa = cnt_q[EpochAw-1:0];
          ep_wd = pos_q[11:0];
          cnt_d = cnt_q + EpochCntW'(1);
          pos_d = pos_q + CountW'(period);
        end else begin
          idx_d   = EpochCntW'(1);
          state_d = ST_RFETCH;
        end
      end
      ST_RFETCH: begin
        if (idx_inc < cnt_q) begin
          state_d = ST_RWAIT;
        end else begin
          idx_d   = '0;
          state_d = ST_EREAD;
        end
      end
      ST_RWAIT: begin
        if (CountW'(win_lo) < win_hi) begin
          scan_addr_d = CountW'(win_lo);
          scan_hi_d   = win_hi;
          first_d     = 1'b1;
          state_d     = ST_RSCAN;
        end else begin
          idx_d   = idx_inc;
          state_d = ST_RFETCH;
        end
      end
      ST_RSCAN: begin
        if (scan_done) begin
          ep_we   = 1'b1;
          idx_d   = idx_inc;
          state_d = ST_RFETCH;
        end
      end
      ST_EREAD: begin
        state_d = ST_EWAIT;
      end
      ST_EWAIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.epoch_position = ep_rd_q;
          out_d.last_epoch     = idx_inc == cnt_q;
          idx_d                = idx_inc;
          state_d              = (idx_inc == cnt_q) ? ST_LOAD : ST_EREAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      n_q         <= '0;
      scan_addr_q <= '0;
      scan_hi_q   <= '0;
      pend_q      <= 1'b0;
      pend_idx_q  <= '0;
      first_q     <= 1'b0;
      best_idx_q  <= '0;
      best_val_q  <= '0;
      rem_q       <= '0;
      bit_q       <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      scan_addr_q <= scan_addr_d;
      scan_hi_q   <= scan_hi_d;
      pend_q      <= pend_d;
      pend_idx_q  <= pend_idx_d;
      first_q     <= first_d;
      best_idx_q  <= best_idx_d;
      best_val_q  <= best_val_d;
      rem_q       <= rem_d;
      bit_q       <= bit_d;
      pos_q       <= pos_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_job_i.we) begin
      smem[q_job_i.addr] <= q_job_i.data;
    end
    if (smp_rd_en) begin
      smp_rd_q <= smem[scan_addr_q[SampleAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ep_we) begin
      emem[ep_wa] <= ep_wd;
    end
    ep_rd_q <= emem[idx_q[EpochAw-1:0]];
  end

endmodule

`default_nettype wire

// ===== sv/pitch_epoch_marker.sv =====
// ----------------------------------------------------------------------------
// pitch_epoch_marker
// Pitch epoch marking over a buffer of samples: global peak, period grid and
// peak refinement of each inner epoch, epochs streamed out in list order.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+----------------
//   in       | in        | in_valid_i / in_stall_o      | pem_in_t
//   out      | out       | out_valid_o / out_stall_i    | pem_out_t
//   cfg      | in        | psel, penable, pwrite, pready| paddr, pwdata
//
// Samples are taken one per cycle, unless the queue is full, through a four-entry
// queue into the sample memory. After the closing sample the back end runs the
// peak scan, the period remainder, the grid build, the refinement of each inner
// epoch and the emission of each epoch, the scans bound by the single sample
// memory read port. Input stalls once the queue fills during a run. No clearing
// pass: memories are written before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module pitch_epoch_marker
  import pem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pem_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output pem_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  pem_cfg_t    cfg_q;
  pem_job_t    push_job, pop_job;
  pem_q_stat_t q_stat;
  logic        q_push, q_pop;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == RegHalfWidth) ? {24'd0, cfg_q.search_half_width}
                                             : {20'd0, cfg_q.pitch_period};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pitch_period      <= PeriodReset;
      cfg_q.search_half_width <= HalfWidthReset;
    end else if (cfg_wr) begin
      if (paddr[2] == RegPitchPeriod) begin
        cfg_q.pitch_period <= pwdata[11:0];
      end else begin
        cfg_q.search_half_width <= pwdata[7:0];
      end
    end
  end

  pem_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_stat.full),
    .q_push_o   (q_push),
    .q_job_o    (push_job)
  );

  pem_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_job_i (push_job),
    .pop_i      (q_pop),
    .pop_job_o  (pop_job),
    .stat_o     (q_stat)
  );

  pem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .q_job_i     (pop_job),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_run_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && pop_job.last) |=> !q_pop)
    else $error("back end kept draining the queue after a closing transfer");
`endif

endmodule

`default_nettype wire
